### rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/i2ctsp_pkg.sv
// Shared types and constants for the I2C temperature sensor poller.
// No dependencies.
package i2ctsp_pkg;

    localparam int INTERVAL_WIDTH = 24;
    localparam int POLL_WIDTH     = 24;
    localparam int ADDR_WIDTH     = 7;
    localparam int PTR_WIDTH      = 8;
    localparam int CFG_IDX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH = 24;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_IDX_POLL = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_IDX_ADDR = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_IDX_PTR  = 2'd2;

    localparam logic [POLL_WIDTH-1:0] POLL_RESET = 24'd100000;
    localparam logic [ADDR_WIDTH-1:0] ADDR_RESET = 7'd72;
    localparam logic [PTR_WIDTH-1:0]  PTR_RESET  = 8'd0;
    localparam logic signed [7:0]     TEMP_RESET = 8'sd100;

    typedef struct packed {
        logic [POLL_WIDTH-1:0] poll_interval;
        logic [ADDR_WIDTH-1:0] sensor_address;
        logic [PTR_WIDTH-1:0]  register_pointer;
    } t_cfg;

    typedef struct packed {
        logic              scl_level;
        logic              sda_pull_low;
        logic signed [7:0] temperature_c;
        logic              reading_fresh;
        logic              bus_busy;
    } t_pins;

endpackage

### rtl/i2c_temp_sensor_poller_core.sv
// Top level of the I2C temperature sensor poller: handshake, config, result register.
// Depends on i2ctsp_pkg and i2ctsp_seq.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_sda_sample): one transfer per bus
//   phase tick, normally one per prescaler strobe, carrying the sampled SDA level.
//   Output channel (o_out_valid / i_out_stall / pin and reading fields): one
//   result per input transfer, giving the SCL level, the SDA pull-down, the held
//   temperature in whole degrees, a fresh flag and bus_busy after that tick.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
//   index 0 poll interval, 1 sensor address, 2 register pointer; other indexes
//   are dropped. Ready is always high; write only while the block is idle.
//   The result is registered and shows in the cycle after its input transfer.
//   Throughput: one tick per cycle unless the output stalls; the sequencer update
//   is a single pass of logic between the state registers and the result register.
//   Stall: the result register holds while i_out_stall is high with a result
//   waiting; o_in_stall rises only then, and a new tick is taken in the same
//   cycle the waiting result transfers out.
//   Reset: both bus lines released, sequencer idle, interval counter zero,
//   temperature 100, registers back to defaults, no result pending.
module i2c_temp_sensor_poller_core #(
    parameter int INTERVAL_WIDTH = i2ctsp_pkg::INTERVAL_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_sda_sample,
    // output channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_scl_level,
    output logic                                  o_sda_pull_low,
    output logic signed [7:0]                     o_temperature_c,
    output logic                                  o_reading_fresh,
    output logic                                  o_bus_busy,
    // config write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [i2ctsp_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_index,
    input  logic [i2ctsp_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data
);

    i2ctsp_pkg::t_cfg  r_cfg;
    i2ctsp_pkg::t_pins seq_pins;
    i2ctsp_pkg::t_pins r_pins;
    logic              r_out_valid;
    logic              in_xfer;
    logic              cfg_xfer;

    // Stall the input only while a result waits and the receiver holds it off.
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_xfer     = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_xfer    = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.poll_interval    <= i2ctsp_pkg::POLL_RESET;
            r_cfg.sensor_address   <= i2ctsp_pkg::ADDR_RESET;
            r_cfg.register_pointer <= i2ctsp_pkg::PTR_RESET;
        end else if (cfg_xfer) begin
            unique case (i_cfg_index)
                i2ctsp_pkg::CFG_IDX_POLL: begin
                    r_cfg.poll_interval <= i_cfg_data[i2ctsp_pkg::POLL_WIDTH-1:0];
                end
                i2ctsp_pkg::CFG_IDX_ADDR: begin
                    r_cfg.sensor_address <= i_cfg_data[i2ctsp_pkg::ADDR_WIDTH-1:0];
                end
                i2ctsp_pkg::CFG_IDX_PTR: begin
                    r_cfg.register_pointer <= i_cfg_data[i2ctsp_pkg::PTR_WIDTH-1:0];
                end
                default: begin
                    // index outside the register list: drop the write
                end
            endcase
        end
    end

    i2ctsp_seq #(
        .INTERVAL_WIDTH (INTERVAL_WIDTH)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (in_xfer),
        .i_sda_sample (i_sda_sample),
        .i_cfg        (r_cfg),
        .o_pins       (seq_pins)
    );

    // Result register: load on every input transfer, hold while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_pins <= seq_pins;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_scl_level     = r_pins.scl_level;
    assign o_sda_pull_low  = r_pins.sda_pull_low;
    assign o_temperature_c = r_pins.temperature_c;
    assign o_reading_fresh = r_pins.reading_fresh;
    assign o_bus_busy      = r_pins.bus_busy;

endmodule

### rtl/i2ctsp_seq.sv
// Transaction sequencer of the I2C temperature poller: one pin change per tick.
// Depends on i2ctsp_pkg (t_cfg, t_pins, reset constants).
module i2ctsp_seq #(
    parameter int INTERVAL_WIDTH = i2ctsp_pkg::INTERVAL_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  logic               i_sda_sample,
    input  i2ctsp_pkg::t_cfg   i_cfg,
    output i2ctsp_pkg::t_pins  o_pins
);

    localparam int CW = ((INTERVAL_WIDTH > i2ctsp_pkg::POLL_WIDTH) ?
                         INTERVAL_WIDTH : i2ctsp_pkg::POLL_WIDTH) + 1;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_START_A = 4'd1;
    localparam logic [3:0] ST_ADDR_W  = 4'd2;
    localparam logic [3:0] ST_POINTER = 4'd3;
    localparam logic [3:0] ST_STOP_A  = 4'd4;
    localparam logic [3:0] ST_START_B = 4'd5;
    localparam logic [3:0] ST_ADDR_R  = 4'd6;
    localparam logic [3:0] ST_READ_HI = 4'd7;
    localparam logic [3:0] ST_READ_LO = 4'd8;
    localparam logic [3:0] ST_STOP_B  = 4'd9;

    logic [INTERVAL_WIDTH-1:0] r_count, n_count;
    logic [3:0]                r_step,  n_step;
    logic [3:0]                r_bit,   n_bit;
    logic [1:0]                r_phase, n_phase;
    logic [7:0]                r_shift, n_shift;
    logic [7:0]                r_high,  n_high;
    logic signed [7:0]         r_held,  n_held;
    logic                      r_scl,   n_scl;
    logic                      r_sda,   n_sda;
    logic                      n_fresh;

    logic [CW-1:0] count_inc;
    logic [CW-1:0] poll_ext;
    logic          poll_due;
    logic          reading;
    logic          ack_slot;
    logic [3:0]    step_inc;

    // Shift register contents on entering a step; other steps keep it.
    function automatic logic [7:0] f_enter_shift(input logic [3:0] s,
                                                 input i2ctsp_pkg::t_cfg c,
                                                 input logic [7:0] cur);
        logic [7:0] v;
        v = cur;
        unique case (s)
            ST_ADDR_W:             v = {c.sensor_address, 1'b0};
            ST_POINTER:            v = c.register_pointer;
            ST_ADDR_R:             v = {c.sensor_address, 1'b1};
            ST_READ_HI, ST_READ_LO: v = 8'd0;
            default:               v = cur;
        endcase
        return v;
    endfunction

    assign count_inc = {{(CW-INTERVAL_WIDTH){1'b0}}, r_count} + CW'(1);
    assign poll_ext  = {{(CW-i2ctsp_pkg::POLL_WIDTH){1'b0}}, i_cfg.poll_interval};
    assign poll_due  = (count_inc >= poll_ext) || (&r_count);
    assign reading   = (r_step == ST_READ_HI) || (r_step == ST_READ_LO);
    assign ack_slot  = r_bit[3];
    assign step_inc  = r_step + 4'd1;

    always_comb begin
        n_count = r_count;
        n_step  = r_step;
        n_bit   = r_bit;
        n_phase = r_phase;
        n_shift = r_shift;
        n_high  = r_high;
        n_held  = r_held;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_fresh = 1'b0;

        unique case (r_step)
            ST_START_A, ST_START_B: begin
                unique case (r_phase)
                    2'd0: begin
                        n_scl   = 1'b1;
                        n_sda   = 1'b1;
                        n_phase = 2'd1;
                    end
                    2'd1: begin
                        n_sda   = 1'b0;
                        n_phase = 2'd2;
                    end
                    default: begin
                        n_scl   = 1'b0;
                        n_step  = step_inc;
                        n_bit   = 4'd0;
                        n_phase = 2'd0;
                        n_shift = f_enter_shift(step_inc, i_cfg, r_shift);
                    end
                endcase
            end
            ST_ADDR_W, ST_POINTER, ST_ADDR_R, ST_READ_HI, ST_READ_LO: begin
                unique case (r_phase)
                    2'd0: begin
                        n_scl = 1'b0;
                        if (!ack_slot) begin
                            n_sda = reading ? 1'b1 : r_shift[7];
                        end else begin
                            // ACK the high data byte, NACK everything else
                            n_sda = (r_step != ST_READ_HI);
                        end
                        n_phase = 2'd1;
                    end
                    2'd1: begin
                        n_scl   = 1'b1;
                        n_phase = 2'd2;
                    end
                    2'd2: begin
                        if (reading && !ack_slot) begin
                            n_shift = {r_shift[6:0], i_sda_sample};
                        end
                        n_phase = 2'd3;
                    end
                    default: begin
                        n_scl = 1'b0;
                        if (ack_slot) begin
                            if (r_step == ST_READ_HI) begin
                                n_high = r_shift;
                            end
                            n_step  = step_inc;
                            n_bit   = 4'd0;
                            n_phase = 2'd0;
                            n_shift = f_enter_shift(step_inc, i_cfg, r_shift);
                        end else begin
                            if (!reading) begin
                                n_shift = {r_shift[6:0], 1'b0};
                            end
                            n_bit   = r_bit + 4'd1;
                            n_phase = 2'd0;
                        end
                    end
                endcase
            end
            ST_STOP_A, ST_STOP_B: begin
                unique case (r_phase)
                    2'd0: begin
                        n_scl   = 1'b0;
                        n_sda   = 1'b0;
                        n_phase = 2'd1;
                    end
                    2'd1: begin
                        n_scl   = 1'b1;
                        n_phase = 2'd2;
                    end
                    default: begin
                        n_sda   = 1'b1;
                        n_bit   = 4'd0;
                        n_phase = 2'd0;
                        if (r_step == ST_STOP_A) begin
                            n_step = ST_START_B;
                        end else begin
                            // the signed high byte is the whole-degree value
                            n_held  = $signed(r_high);
                            n_fresh = 1'b1;
                            n_count = '0;
                            n_step  = ST_IDLE;
                        end
                    end
                endcase
            end
            default: begin
                n_step  = ST_IDLE;
                n_bit   = 4'd0;
                n_phase = 2'd0;
                if (poll_due) begin
                    n_count = '0;
                    n_step  = ST_START_A;
                end else begin
                    n_count = count_inc[INTERVAL_WIDTH-1:0];
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_step  <= ST_IDLE;
            r_bit   <= 4'd0;
            r_phase <= 2'd0;
            r_shift <= 8'd0;
            r_high  <= 8'd0;
            r_held  <= i2ctsp_pkg::TEMP_RESET;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
        end else if (i_advance) begin
            r_count <= n_count;
            r_step  <= n_step;
            r_bit   <= n_bit;
            r_phase <= n_phase;
            r_shift <= n_shift;
            r_high  <= n_high;
            r_held  <= n_held;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
        end
    end

    assign o_pins.scl_level     = n_scl;
    assign o_pins.sda_pull_low  = ~n_sda;
    assign o_pins.temperature_c = n_held;
    assign o_pins.reading_fresh = n_fresh;
    assign o_pins.bus_busy      = (n_step != ST_IDLE);

endmodule

### rtl/i2ctsp_checker.sv
// Port-level checker for the I2C temperature sensor poller, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module i2ctsp_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic              o_scl_level,
    input logic              o_sda_pull_low,
    input logic signed [7:0] o_temperature_c,
    input logic              o_reading_fresh,
    input logic              o_bus_busy
);

    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable({o_scl_level, o_sda_pull_low, o_temperature_c, o_reading_fresh, o_bus_busy}), "stalled result changed")

    `ASSERT_IMP(a_in_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall, "input stalled without a waiting result")

    `ASSERT_NXT(a_result_follows, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_out_valid, "no result after an input transfer")

    `ASSERT_IMP(a_fresh_idle, i_clk, i_rst_n, o_out_valid && o_reading_fresh, !o_bus_busy && !o_sda_pull_low && o_scl_level, "fresh reading while bus not released")

endmodule

bind i2c_temp_sensor_poller_core i2ctsp_checker u_i2ctsp_checker (.*);

### verif/i2c_temp_sensor_poller_core_tb.sv
// Self-checking testbench for i2c_temp_sensor_poller_core: bus pins and readings per tick.
// Depends on i2ctsp_pkg and the RTL of the core; a built-in sequencer model predicts results.
module i2c_temp_sensor_poller_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2ctsp_pkg::*;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_IDX_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 64;
    localparam int MAX_SHOWN   = 10;

    // Sequencer steps of one poll transaction, in bus order.
    typedef enum logic [4:0] {
        SEQ_IDLE, SEQ_START_W, SEQ_ADDR_W, SEQ_POINTER, SEQ_STOP_W,
        SEQ_START_R, SEQ_ADDR_R, SEQ_READ_HI, SEQ_READ_LO, SEQ_STOP_R
    } t_seq;

    // DUT ports; every input starts at a known value.
    logic                      i_clk        = 1'b0;
    logic                      i_rst_n      = 1'b0;
    logic                      i_in_valid   = 1'b0;
    logic                      o_in_stall;
    logic                      i_sda_sample = 1'b0;
    logic                      o_out_valid;
    logic                      i_out_stall  = 1'b0;
    logic                      o_scl_level;
    logic                      o_sda_pull_low;
    logic signed [7:0]         o_temperature_c;
    logic                      o_reading_fresh;
    logic                      o_bus_busy;
    logic                      i_cfg_valid  = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_WIDTH-1:0]  i_cfg_index  = '0;
    logic [CFG_DATA_WIDTH-1:0] i_cfg_data   = '0;

    // Model copy of the registers and the sequencer state.
    logic [POLL_WIDTH-1:0]     poll_cfg;
    logic [ADDR_WIDTH-1:0]     addr_cfg;
    logic [PTR_WIDTH-1:0]      ptr_cfg;
    logic [INTERVAL_WIDTH-1:0] wait_count;
    t_seq                      step;
    logic [3:0]                bit_idx;
    logic [1:0]                phase;
    logic [7:0]                shreg;
    logic [7:0]                hi_byte;
    logic signed [7:0]         temp_held;
    logic                      scl_q;
    logic                      sda_q;

    // Pins expected from the core, oldest first.
    t_pins pins_due[$];
    int    bad_results = 0;

    // Traffic shaping.
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    logic hold_start    = 1'b0;
    logic hold_on       = 1'b0;
    logic tick_fresh    = 1'b0;
    logic follow_target = 1'b1;
    logic [7:0] target_hi = 8'h00;
    logic [7:0] target_lo = 8'h00;

    i2c_temp_sensor_poller_core DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Sequencer model
    // ------------------------------------------------------------------

    // Enter a step: clear the slot counters and load the byte it sends.
    function automatic void load_step(input t_seq s);
        step    = s;
        bit_idx = 4'd0;
        phase   = 2'd0;
        case (s)
            SEQ_ADDR_W:               shreg = {addr_cfg, 1'b0};
            SEQ_POINTER:              shreg = ptr_cfg;
            SEQ_ADDR_R:               shreg = {addr_cfg, 1'b1};
            SEQ_READ_HI, SEQ_READ_LO: shreg = 8'h00;
            default: ;
        endcase
    endfunction

    // One tick of a byte: eight data slots and an acknowledge slot, four phases each.
    function automatic void bit_slot(input logic sda, input logic reading);
        logic ack;
        ack = bit_idx[3];
        case (phase)
            2'd0: begin
                scl_q = 1'b0;
                // Master releases SDA when reading; ACK the high byte, NACK the low one.
                if (!ack)
                    sda_q = reading ? 1'b1 : shreg[7];
                else
                    sda_q = (step != SEQ_READ_HI);
                phase = 2'd1;
            end
            2'd1: begin
                scl_q = 1'b1;
                phase = 2'd2;
            end
            2'd2: begin
                // Sample SDA with SCL high.
                if (reading && !ack)
                    shreg = {shreg[6:0], sda};
                phase = 2'd3;
            end
            default: begin
                scl_q = 1'b0;
                if (!reading && !ack)
                    shreg = {shreg[6:0], 1'b0};
                if (ack) begin
                    if (step == SEQ_READ_HI)
                        hi_byte = shreg;
                    load_step(t_seq'(step + 1));
                end else begin
                    bit_idx = bit_idx + 4'd1;
                    phase   = 2'd0;
                end
            end
        endcase
    endfunction

    // Advance the model by one tick and return the pins that the core shows after it.
    function automatic t_pins next_pins(input logic sda);
        t_pins                   p;
        logic                    fresh;
        logic [INTERVAL_WIDTH:0] count_next;
        fresh = 1'b0;
        case (step)
            SEQ_START_W, SEQ_START_R: begin
                if (phase == 2'd0) begin
                    scl_q = 1'b1;
                    sda_q = 1'b1;
                    phase = 2'd1;
                end else if (phase == 2'd1) begin
                    sda_q = 1'b0;
                    phase = 2'd2;
                end else begin
                    scl_q = 1'b0;
                    load_step(t_seq'(step + 1));
                end
            end
            SEQ_ADDR_W, SEQ_POINTER, SEQ_ADDR_R: bit_slot(sda, 1'b0);
            SEQ_READ_HI, SEQ_READ_LO:            bit_slot(sda, 1'b1);
            SEQ_STOP_W, SEQ_STOP_R: begin
                if (phase == 2'd0) begin
                    scl_q = 1'b0;
                    sda_q = 1'b0;
                    phase = 2'd1;
                end else if (phase == 2'd1) begin
                    scl_q = 1'b1;
                    phase = 2'd2;
                end else begin
                    sda_q = 1'b1;
                    if (step == SEQ_STOP_W) begin
                        load_step(SEQ_START_R);
                    end else begin
                        // The high byte alone is the 12-bit code shifted down to degrees.
                        temp_held  = hi_byte;
                        fresh      = 1'b1;
                        wait_count = '0;
                        load_step(SEQ_IDLE);
                    end
                end
            end
            default: begin
                step    = SEQ_IDLE;
                bit_idx = 4'd0;
                phase   = 2'd0;
                // A zero interval acts as one; a full counter starts the poll as well.
                count_next = wait_count + 1'b1;
                if (count_next >= poll_cfg || &wait_count) begin
                    wait_count = '0;
                    load_step(SEQ_START_W);
                end else begin
                    wait_count = count_next[INTERVAL_WIDTH-1:0];
                end
            end
        endcase
        p.scl_level     = scl_q;
        p.sda_pull_low  = ~sda_q;
        p.temperature_c = temp_held;
        p.reading_fresh = fresh;
        p.bus_busy      = (step != SEQ_IDLE);
        return p;
    endfunction

    // Play the sensor: drive the wanted reading during read data slots, noise elsewhere.
    function automatic logic pick_sda();
        if (follow_target && !bit_idx[3] && step == SEQ_READ_HI)
            return target_hi[3'd7 - bit_idx[2:0]];
        if (follow_target && !bit_idx[3] && step == SEQ_READ_LO)
            return target_lo[3'd7 - bit_idx[2:0]];
        return 1'($urandom_range(1));
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one tick, hold it until the transfer, predict it, then idle at random.
    task automatic send_tick(input logic sda);
        t_pins due;
        i_in_valid   <= 1'b1;
        i_sda_sample <= sda;
        do @(posedge i_clk); while (o_in_stall);
        due = next_pins(sda);
        pins_due.push_back(due);
        tick_fresh = due.reading_fresh;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid   <= 1'b0;
            i_sda_sample <= 1'($urandom_range(1));
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Run ticks until the next reading is stored.
    task automatic run_transaction();
        do send_tick(pick_sda()); while (!tick_fresh);
    endtask

    // Drop valid and wait until every predicted result has come out.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pins_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Write one register; valid stays high for a following write.
    task automatic cfg_write(input logic [CFG_IDX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_IDX_POLL: poll_cfg = data[POLL_WIDTH-1:0];
            CFG_IDX_ADDR: addr_cfg = data[ADDR_WIDTH-1:0];
            CFG_IDX_PTR:  ptr_cfg  = data[PTR_WIDTH-1:0];
            default: ;
        endcase
    endtask

    // Write all registers once the output side is quiet, plus a write the core drops.
    task automatic apply_config(input logic [POLL_WIDTH-1:0] poll,
                                input logic [ADDR_WIDTH-1:0] addr,
                                input logic [PTR_WIDTH-1:0]  ptr);
        drain_results();
        cfg_write(CFG_IDX_POLL, CFG_DATA_WIDTH'(poll));
        cfg_write(CFG_IDX_ADDR, CFG_DATA_WIDTH'(addr));
        cfg_write(CFG_IDX_PTR,  CFG_DATA_WIDTH'(ptr));
        cfg_write(CFG_IDX_UNUSED, CFG_DATA_WIDTH'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // Receiver: stall at random, and hard for the whole hold-off.
    always @(posedge i_clk)
        i_out_stall <= hold_on || ($urandom_range(99) < stall_pct);

    // Long hold-off, counted here so the sender keeps offering ticks meanwhile.
    initial begin : receiver_holdoff
        wait (hold_start);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : check_result
        t_pins seen;
        t_pins want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.scl_level     = o_scl_level;
            seen.sda_pull_low  = o_sda_pull_low;
            seen.temperature_c = o_temperature_c;
            seen.reading_fresh = o_reading_fresh;
            seen.bus_busy      = o_bus_busy;
            if (pins_due.size() == 0) begin
                bad_results++;
                if (bad_results <= MAX_SHOWN)
                    $display("%0t: result with none expected: scl %b pull %b temp %0d fresh %b busy %b",
                             $realtime, seen.scl_level, seen.sda_pull_low,
                             seen.temperature_c, seen.reading_fresh, seen.bus_busy);
            end else begin
                want = pins_due.pop_front();
                if (seen.scl_level     !== want.scl_level     ||
                    seen.sda_pull_low  !== want.sda_pull_low  ||
                    seen.temperature_c !== want.temperature_c ||
                    seen.reading_fresh !== want.reading_fresh ||
                    seen.bus_busy      !== want.bus_busy) begin
                    bad_results++;
                    if (bad_results <= MAX_SHOWN)
                        $display({"%0t: mismatch, expected scl %b pull %b temp %0d fresh %b busy %b,",
                                  " got scl %b pull %b temp %0d fresh %b busy %b"},
                                 $realtime, want.scl_level, want.sda_pull_low,
                                 want.temperature_c, want.reading_fresh, want.bus_busy,
                                 seen.scl_level, seen.sda_pull_low, seen.temperature_c,
                                 seen.reading_fresh, seen.bus_busy);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Default registers: long interval, so the bus stays idle at 100 degrees.
    task automatic test_reset_state();
        repeat (12) send_tick(1'($urandom_range(1)));
    endtask

    // Largest interval counts on without polling; zero and one poll right away.
    task automatic test_poll_limits();
        apply_config({POLL_WIDTH{1'b1}}, ADDR_RESET, PTR_RESET);
        repeat (8) send_tick(1'($urandom_range(1)));
        {target_hi, target_lo} = 16'h1930;
        apply_config('0, ADDR_RESET, PTR_RESET);
        run_transaction();
        {target_hi, target_lo} = 16'hE6C0;
        apply_config(POLL_WIDTH'(1), ADDR_RESET, PTR_RESET);
        run_transaction();
    endtask

    // Hottest, coldest (-2048 code), zero and minus one, with address and pointer extremes.
    task automatic test_reading_extremes();
        for (int k = 0; k < 4; k++) begin
            case (k)
                0: begin
                    {target_hi, target_lo} = 16'h7FF0;
                    apply_config(POLL_WIDTH'(2), 7'h00, 8'hFF);
                end
                1: begin
                    {target_hi, target_lo} = 16'h8000;
                    apply_config(POLL_WIDTH'(3), 7'h7F, 8'h00);
                end
                2: begin
                    {target_hi, target_lo} = 16'h0000;
                    apply_config(POLL_WIDTH'(1), 7'h2A, 8'h55);
                end
                default: begin
                    {target_hi, target_lo} = 16'hFFF0;
                    apply_config(POLL_WIDTH'(5), 7'h55, 8'hAA);
                end
            endcase
            run_transaction();
        end
    endtask

    // Change registers in the middle of the address byte: it keeps the old address,
    // the pointer and the read address pick up the new values.
    task automatic test_midway_change();
        {target_hi, target_lo} = 16'h2A50;
        apply_config(POLL_WIDTH'(3), 7'h15, 8'h3C);
        while (!(step == SEQ_ADDR_W && bit_idx == 4'd3))
            send_tick(pick_sda());
        apply_config(POLL_WIDTH'(3), 7'h6A, 8'hC3);
        run_transaction();
    endtask

    // Random ticks in four idling phases; mostly well-formed readings, some noise.
    task automatic test_random_traffic();
        for (int ph = 0; ph < 4; ph++) begin
            apply_config(($urandom_range(9) == 0) ? '0 : POLL_WIDTH'($urandom_range(1, 40)),
                         ADDR_WIDTH'($urandom), PTR_WIDTH'($urandom));
            case (ph)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 81; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 81; end
                default: begin send_idle_pct = 13; stall_pct = 13; end
            endcase
            for (int n = 0; n < 90; n++) begin
                // Block the output while ticks keep coming, so the core stalls its input.
                if (ph == 0 && n == 20)
                    hold_start = 1'b1;
                send_tick(pick_sda());
                if (tick_fresh) begin
                    follow_target = ($urandom_range(99) < 85);
                    case ($urandom_range(5))
                        0:       {target_hi, target_lo} = 16'h7FF0;
                        1:       {target_hi, target_lo} = 16'h8000;
                        2:       {target_hi, target_lo} = 16'h0000;
                        3:       {target_hi, target_lo} = 16'hFFF0;
                        default: {target_hi, target_lo} = 16'($urandom);
                    endcase
                end
            end
        end
    endtask

    initial begin : main_sequence
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Model state after reset.
        poll_cfg   = POLL_RESET;
        addr_cfg   = ADDR_RESET;
        ptr_cfg    = PTR_RESET;
        wait_count = '0;
        step       = SEQ_IDLE;
        bit_idx    = 4'd0;
        phase      = 2'd0;
        shreg      = 8'h00;
        hi_byte    = 8'h00;
        temp_held  = TEMP_RESET;
        scl_q      = 1'b1;
        sda_q      = 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_poll_limits();
        test_reading_extremes();
        test_midway_change();
        test_random_traffic();

        drain_results();
        // Let a stray result show up.
        repeat (4) @(posedge i_clk);
        if (bad_results == 0 && pins_due.size() == 0)
            $display("i2c_temp_sensor_poller_core regression: pass");
        else
            $display("i2c_temp_sensor_poller_core regression: fail");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("i2c_temp_sensor_poller_core regression: fail");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/i2ctsp_pkg.sv
rtl/i2ctsp_seq.sv
rtl/i2c_temp_sensor_poller_core.sv
rtl/i2ctsp_checker.sv
verif/i2c_temp_sensor_poller_core_tb.sv
